/* sv/ihex_pkg.sv */
package ihex_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;

    // record types
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    // event codes
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_ACCEPT   = 3'd1;
    localparam logic [2:0] KIND_EOF      = 3'd2;
    localparam logic [2:0] KIND_MISMATCH = 3'd3;
    localparam logic [2:0] KIND_BADHEX   = 3'd4;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN     = 4'd1,
        PH_ADDR_HI = 4'd2,
        PH_ADDR_LO = 4'd3,
        PH_TYPE    = 4'd4,
        PH_DATA    = 4'd5,
        PH_CSUM    = 4'd6,
        PH_DONE    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        digit_count;
        logic [3:0]  high_nibble;
        logic [7:0]  bytes_left;
        logic [15:0] offset_address;
        logic [7:0]  type_reg;
        logic [7:0]  running_sum;
        logic [15:0] upper_address;
        logic [15:0] pending_upper;
        logic [7:0]  byte_index;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [31:0] address;
        logic [7:0]  data;
        logic [7:0]  rec_kind;
    } parse_result_t;

    // hex digit decode, bit 4 set for a valid digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            case (c) inside
                [8'h30:8'h39]:
                begin
                    d = c - 8'h30;
                    hex_nibble = {1'b1, d[3:0]};
                end
                [8'h61:8'h66]:
                begin
                    d = c - 8'h57;
                    hex_nibble = {1'b1, d[3:0]};
                end
                [8'h41:8'h46]:
                begin
                    d = c - 8'h37;
                    hex_nibble = {1'b1, d[3:0]};
                end
                default:
                begin
                    hex_nibble = 5'b0_0000;
                end
            endcase
        end
    endfunction

endpackage

/* sv/ihex_step.sv */
module ihex_step
    import ihex_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    character,
    input  logic          check_enable,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [4:0]  nib;
    logic [7:0]  pair_byte;
    logic [7:0]  sum_next;
    logic        sum_bad;
    logic        pair_done;

    assign nib       = hex_nibble(character);
    assign pair_byte = {cur.high_nibble, nib[3:0]};
    assign sum_next  = cur.running_sum + pair_byte;
    assign sum_bad   = check_enable && (sum_next != 8'h00);
    assign pair_done = nib[4] && cur.digit_count;

    // next state
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_HUNT:
            begin
                if (character == COLON_CHAR)
                begin
                    nxt                = '0;
                    nxt.phase          = PH_LEN;
                    nxt.upper_address  = cur.upper_address;
                end
            end
            PH_DONE, PH_ERROR:
            begin
                nxt = cur;
            end
            default:
            begin
                if (!nib[4])
                begin
                    nxt.phase = PH_ERROR;
                end
                else if (!cur.digit_count)
                begin
                    nxt.high_nibble = nib[3:0];
                    nxt.digit_count = 1'b1;
                end
                else
                begin
                    nxt.digit_count = 1'b0;
                    nxt.running_sum = sum_next;
                    case (cur.phase)
                        PH_LEN:
                        begin
                            nxt.bytes_left = pair_byte;
                            nxt.phase      = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            nxt.offset_address = {pair_byte, 8'h00};
                            nxt.phase          = PH_ADDR_LO;
                        end
                        PH_ADDR_LO:
                        begin
                            nxt.offset_address = {cur.offset_address[15:8], pair_byte};
                            nxt.phase          = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            nxt.type_reg = pair_byte;
                            nxt.phase    = (cur.bytes_left != 8'h00) ? PH_DATA : PH_CSUM;
                        end
                        PH_DATA:
                        begin
                            if (cur.byte_index == 8'h00)
                                nxt.pending_upper = {pair_byte, 8'h00};
                            else if (cur.byte_index == 8'h01)
                                nxt.pending_upper = {cur.pending_upper[15:8], pair_byte};
                            nxt.byte_index = cur.byte_index + 8'h01;
                            nxt.bytes_left = cur.bytes_left - 8'h01;
                            if (cur.bytes_left == 8'h01)
                                nxt.phase = PH_CSUM;
                        end
                        PH_CSUM:
                        begin
                            nxt.phase = PH_HUNT;
                            if (!sum_bad)
                            begin
                                if (cur.type_reg == REC_EOF)
                                    nxt.phase = PH_DONE;
                                else if (cur.type_reg == REC_EXT_LIN)
                                    nxt.upper_address = cur.pending_upper;
                            end
                        end
                        default:
                        begin
                            nxt.phase = PH_HUNT;
                        end
                    endcase
                end
            end
        endcase
    end

    // result
    always_comb
    begin
        res          = '0;
        res.rec_kind = cur.type_reg;
        case (cur.phase)
            PH_HUNT, PH_DONE, PH_ERROR:
            begin
                res.valid = 1'b0;
            end
            default:
            begin
                if (!nib[4])
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BADHEX;
                end
                else if (pair_done && cur.phase == PH_DATA && cur.type_reg == REC_DATA)
                begin
                    res.valid   = 1'b1;
                    res.kind    = KIND_DATA;
                    res.address = {cur.upper_address, 16'h0000}
                                + {16'h0000, cur.offset_address}
                                + {24'h000000, cur.byte_index};
                    res.data    = pair_byte;
                end
                else if (pair_done && cur.phase == PH_CSUM)
                begin
                    res.valid = 1'b1;
                    if (sum_bad)
                        res.kind = KIND_MISMATCH;
                    else if (cur.type_reg == REC_EOF)
                        res.kind = KIND_EOF;
                    else
                        res.kind = KIND_ACCEPT;
                end
            end
        endcase
    end

endmodule

/* sv/intel_hex_record_parser_core.sv */
// Intel HEX record parser. Takes the file text one character per request and
// reports data bytes with their full 32-bit address, accepted records, end of
// file, checksum mismatches and bad hex digits. One character is taken every
// clock cycle when the result side keeps up; a character passes an input
// register and the parse logic into the result register; a held character is
// parsed only once the result register can take its event. The rate is set
// by the single parse step (nibble decode, 8-bit running sum, 32-bit address add)
// between those two registers. After end of file or a bad hex digit the block
// takes characters but reports nothing more until reset. check_enable (reset 1)
// is written through cfg_we/cfg_data; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module intel_hex_record_parser_core
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_we,
    input  logic        cfg_data,

    // character stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,

    // event stream
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [31:0] byte_address,
    output logic [7:0]  data_byte,
    output logic [7:0]  record_kind
);

    logic          check_enable_reg;
    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    char_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    logic          step_fire;
    logic          out_valid_reg;
    logic          out_valid_next;
    parse_result_t out_reg;

    // a held character is parsed once the result register can take its event
    assign step_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_fire;

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (step_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (step_fire)
            out_valid_next = step_res.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // parse logic for one character
    ihex_step u_step (
        .cur          (state_reg),
        .character    (char_reg),
        .check_enable (check_enable_reg),
        .nxt          (state_next),
        .res          (step_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b1;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                check_enable_reg <= cfg_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= character;
        if (step_fire && step_res.valid)
            out_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_reg.kind;
    assign byte_address = out_reg.address;
    assign data_byte    = out_reg.data;
    assign record_kind  = out_reg.rec_kind;

`ifndef SYNTHESIS
    // end of file is final until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE |=> state_reg.phase == PH_DONE)
        else $error("parser left end-of-file state");

    // no events once a bad digit was seen
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && state_reg.phase == PH_ERROR |-> !step_res.valid)
        else $error("event produced in error state");

    // data byte events only come from data records
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_DATA |-> record_kind == REC_DATA)
        else $error("data byte from non-data record");

    // only data byte events carry address and data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_DATA |-> byte_address == 32'h0 && data_byte == 8'h0)
        else $error("non-data event carries payload");
`endif

endmodule
